// ===== rtl/core/hne_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hne_pkg
// Shared types and constants of the Hopfield network engine.
// ----------------------------------------------------------------------------
package hne_pkg;

    localparam int CMD_W      = 2;
    localparam int SPIN_W     = 64;
    localparam int CNT_W      = 20;
    localparam int EQ_W       = 8;
    localparam int STRENGTH_W = 20;
    localparam int STRENGTH_F = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 20'd655;
    localparam logic [EQ_W-1:0]       EQ_RESET       = 8'd20;
    localparam logic [CNT_W-1:0]      LIMIT_RESET    = 20'd1000000;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_LEARN   = 2'd1,
        CMD_UNLEARN = 2'd2,
        CMD_RELAX   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRENGTH = 2'd0,
        CFG_EQ       = 2'd1,
        CFG_LIMIT    = 2'd2,
        CFG_NONE     = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_ZERO  = 2'd0,
        OP_ADD   = 2'd1,
        OP_FIELD = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_INIT_WAIT,
        ST_IDLE,
        ST_WALK,
        ST_CHECK,
        ST_SWEEP,
        ST_EVAL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic unlearn;
        logic walk;
        t_op  op;
        logic step;
        logic fold;
        logic fold_keep;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
        logic same;
        logic back;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== rtl/core/hopfield_network_engine_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hopfield_network_engine_core
// Hopfield coupling store with clear, learn, unlearn and synchronous relax.
// ----------------------------------------------------------------------------
// Clear, learn and unlearn walk the store once, one entry per cycle, and then
// offer the result; the next command is taken once the result has been taken.
// Relax walks the store once per sweep, bound by the
// single read port of the coupling store; one command at a time.
// After reset a clearing pass walks the store and zeroes it;
// no input is taken until it ends. Configuration writes are always taken.
module hopfield_network_engine_core import hne_pkg::*; #(
    parameter int NEURONS     = 64,
    parameter int WEIGHT_BITS = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire [63:0]            i_s_axis_tdata,   // [63:0] spin_vector
    input  wire [1:0]             i_s_axis_tuser,   // [1:0] cmd
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    // [63:0] final_state, [83:64] sweep_count, [84] hit_limit,
    // [85] weight_saturated, [87:86] zero
    output logic [87:0]           o_m_axis_tdata,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data
);

    t_dp_cmd               dp_cmd;
    t_dp_stat              dp_stat;
    logic [STRENGTH_W-1:0] strength;
    logic [CNT_W-1:0]      count;
    logic                  hit;
    logic                  relax;
    logic [SPIN_W-1:0]     cur;
    logic                  sat;

    hne_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_cmd    (i_s_axis_tuser),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat),
        .o_strength  (strength),
        .o_count     (count),
        .o_hit       (hit),
        .o_relax     (relax)
    );

    hne_dp #(
        .NEURONS     (NEURONS),
        .WEIGHT_BITS (WEIGHT_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_spin     (i_s_axis_tdata),
        .i_strength (strength),
        .o_stat     (dp_stat),
        .o_cur      (cur),
        .o_sat      (sat)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = {2'b00, sat, hit, count, (relax ? cur : {SPIN_W{1'b0}})};

endmodule
`default_nettype wire

// ===== rtl/core/hne_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hne_dp
// Coupling store, entry walker, Hebbian update and field accumulation.
// ----------------------------------------------------------------------------
module hne_dp import hne_pkg::*; #(
    parameter int NEURONS     = 64,
    parameter int WEIGHT_BITS = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  wire [SPIN_W-1:0]      i_spin,
    input  wire [STRENGTH_W-1:0]  i_strength,
    output t_dp_stat              o_stat,
    output logic [SPIN_W-1:0]     o_cur,
    output logic                  o_sat
);

    localparam int IB    = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int AB    = 2 * IB;
    localparam int DEPTH = 1 << AB;
    localparam int DW    = FRAC_BITS + 5;
    localparam int SW    = ((WEIGHT_BITS > DW) ? WEIGHT_BITS : DW) + 1;
    localparam int AW    = WEIGHT_BITS + IB + 1;
    localparam logic [IB-1:0] LAST = IB'(NEURONS - 1);

    logic [WEIGHT_BITS-1:0] mem [DEPTH];

    logic               r_busy;
    t_op                r_op;
    logic               r_unl;
    logic [IB-1:0]      r_i, r_j;
    logic               r_v1;
    logic [IB-1:0]      r_i1, r_j1;
    logic [WEIGHT_BITS-1:0] r_rd;
    logic [AW-1:0]      r_acc;
    logic [SPIN_W-1:0]  r_cur, r_prev, r_nxt;
    logic               r_have_prev;
    logic               r_sat;

    logic [SPIN_W-1:0]            mask;
    logic [STRENGTH_W+FRAC_BITS-1:0] d_wide;
    logic signed [SW-1:0]         delta, sum, wmax, wmin;
    logic                         same_pair, clamp_hi, clamp_lo;
    logic [WEIGHT_BITS-1:0]       wdata;
    logic                         we;
    logic signed [AW-1:0]         term, acc_next;

    always_comb begin
        for (int k = 0; k < SPIN_W; k++) begin
            mask[k] = (k < NEURONS);
        end
    end

    // Align the Q4.16 strength to the weight fraction, truncating dropped bits.
    assign d_wide = {i_strength, {FRAC_BITS{1'b0}}};

    always_comb begin
        wmax      = SW'((SW'(1) <<< (WEIGHT_BITS - 1)) - SW'(1));
        wmin      = -wmax - SW'(1);
        if (r_unl) begin
            delta = -SW'(d_wide[STRENGTH_W+FRAC_BITS-1:STRENGTH_F]);
        end else begin
            delta = SW'(1) <<< FRAC_BITS;
        end
        same_pair = (r_cur[r_i1] == r_cur[r_j1]);
        sum       = SW'(signed'(r_rd)) + (same_pair ? delta : -delta);
        clamp_hi  = (sum > wmax);
        clamp_lo  = (sum < wmin);
        priority if (clamp_hi) begin
            wdata = wmax[WEIGHT_BITS-1:0];
        end else if (clamp_lo) begin
            wdata = wmin[WEIGHT_BITS-1:0];
        end else begin
            wdata = sum[WEIGHT_BITS-1:0];
        end
        we = r_v1 && ((r_op == OP_ZERO) || ((r_op == OP_ADD) && (r_i1 != r_j1)));
        if (r_op == OP_ZERO) begin
            wdata = '0;
        end
        term     = r_cur[r_j1] ? AW'(signed'(r_rd)) : -AW'(signed'(r_rd));
        acc_next = signed'(r_acc) + term;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[{r_i1, r_j1}] <= wdata;
        end
        r_rd <= mem[{r_i, r_j}];
        r_i1 <= r_i;
        r_j1 <= r_j;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_v1        <= 1'b0;
            r_op        <= OP_ZERO;
            r_unl       <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_acc       <= '0;
            r_cur       <= '0;
            r_prev      <= '0;
            r_nxt       <= '0;
            r_have_prev <= 1'b0;
            r_sat       <= 1'b0;
        end else begin
            r_v1 <= r_busy;
            if (i_cmd.load) begin
                r_cur       <= i_spin & mask;
                r_prev      <= i_spin & mask;
                r_have_prev <= 1'b0;
                r_sat       <= 1'b0;
                r_unl       <= i_cmd.unlearn;
            end
            if (i_cmd.walk) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                r_i    <= '0;
                r_j    <= '0;
                r_acc  <= '0;
                r_nxt  <= '0;
            end else if (r_busy) begin
                if (r_j == LAST) begin
                    r_j <= '0;
                    r_i <= r_i + IB'(1);
                    if (r_i == LAST) begin
                        r_busy <= 1'b0;
                    end
                end else begin
                    r_j <= r_j + IB'(1);
                end
            end
            if (we && (r_op == OP_ADD) && (clamp_hi || clamp_lo)) begin
                r_sat <= 1'b1;
            end
            if (r_v1 && (r_op == OP_FIELD)) begin
                if (r_j1 == LAST) begin
                    r_nxt[r_i1] <= (acc_next > 0);
                    r_acc       <= '0;
                end else begin
                    r_acc <= acc_next;
                end
            end
            if (i_cmd.step) begin
                r_prev      <= r_cur;
                r_cur       <= r_nxt;
                r_have_prev <= 1'b1;
            end else if (i_cmd.fold) begin
                r_cur <= i_cmd.fold_keep ? r_cur : r_nxt;
            end
        end
    end

    assign o_stat.done = r_v1 && (r_i1 == LAST) && (r_j1 == LAST);
    assign o_stat.same = (r_nxt == r_cur);
    assign o_stat.back = r_have_prev && (r_nxt == r_prev);
    assign o_cur       = r_cur;
    assign o_sat       = r_sat;

endmodule
`default_nettype wire

// ===== rtl/core/hne_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hne_ctrl
// Command sequencer: configuration registers, sweep and convergence counting.
// ----------------------------------------------------------------------------
module hne_ctrl import hne_pkg::*; (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire [CMD_W-1:0]       i_in_cmd,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    input  wire                   i_cfg_valid,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    output t_dp_cmd               o_cmd,
    input  t_dp_stat              i_stat,
    output logic [STRENGTH_W-1:0] o_strength,
    output logic [CNT_W-1:0]      o_count,
    output logic                  o_hit,
    output logic                  o_relax
);

    t_state            r_state, n_state;
    t_cmd              r_cmd;
    logic [STRENGTH_W-1:0] r_strength;
    logic [EQ_W-1:0]   r_eq;
    logic [CNT_W-1:0]  r_limit;
    logic [CNT_W-1:0]  r_count;
    logic [EQ_W-1:0]   r_conv;
    logic              r_hit;
    logic              accept;
    logic              go_on;
    logic [CNT_W-1:0]  count_inc;

    assign accept    = i_in_valid && o_in_ready;
    assign go_on     = (r_conv < r_eq) && (r_count < r_limit);
    assign count_inc = r_count + CNT_W'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT:      n_state = ST_INIT_WAIT;
            ST_INIT_WAIT: if (i_stat.done) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (t_cmd'(i_in_cmd) == CMD_RELAX) ? ST_CHECK : ST_WALK;
                end
            end
            ST_WALK:      if (i_stat.done) n_state = ST_OUT;
            ST_CHECK:     n_state = go_on ? ST_SWEEP : ST_OUT;
            ST_SWEEP:     if (i_stat.done) n_state = ST_EVAL;
            ST_EVAL: begin
                if (!i_stat.same && i_stat.back) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_CHECK;
                end
            end
            ST_OUT:       if (i_out_ready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = OP_ZERO;
        o_in_ready      = 1'b0;
        o_out_valid     = 1'b0;
        unique case (r_state)
            ST_INIT: o_cmd.walk = 1'b1;
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load    = i_in_valid;
                o_cmd.unlearn = (t_cmd'(i_in_cmd) == CMD_UNLEARN);
                o_cmd.walk    = i_in_valid && (t_cmd'(i_in_cmd) != CMD_RELAX);
                o_cmd.op      = (t_cmd'(i_in_cmd) == CMD_CLEAR) ? OP_ZERO : OP_ADD;
            end
            ST_CHECK: begin
                o_cmd.walk = go_on;
                o_cmd.op   = OP_FIELD;
            end
            ST_EVAL: begin
                o_cmd.step      = i_stat.same || !i_stat.back;
                o_cmd.fold      = !i_stat.same && i_stat.back;
                // parity of the sweeps left decides where the oscillation between two states ends
                o_cmd.fold_keep = r_limit[0] ^ count_inc[0];
            end
            ST_OUT:  o_out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_cmd      <= CMD_CLEAR;
            r_strength <= STRENGTH_RESET;
            r_eq       <= EQ_RESET;
            r_limit    <= LIMIT_RESET;
            r_count    <= '0;
            r_conv     <= '0;
            r_hit      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_STRENGTH: r_strength <= i_cfg_data;
                    CFG_EQ:       r_eq       <= i_cfg_data[EQ_W-1:0];
                    CFG_LIMIT:    r_limit    <= i_cfg_data;
                    default:      ;
                endcase
            end
            if (accept) begin
                r_cmd   <= t_cmd'(i_in_cmd);
                r_count <= '0;
                r_conv  <= '0;
                r_hit   <= 1'b0;
            end
            if (r_state == ST_CHECK && !go_on) begin
                r_hit <= (r_conv < r_eq);
            end
            if (r_state == ST_EVAL) begin
                if (i_stat.same) begin
                    r_count <= count_inc;
                    r_conv  <= r_conv + EQ_W'(1);
                end else if (i_stat.back) begin
                    r_count <= r_limit;
                    r_hit   <= 1'b1;
                end else begin
                    r_count <= count_inc;
                end
            end
        end
    end

    assign o_strength = r_strength;
    assign o_count    = r_count;
    assign o_hit      = r_hit;
    assign o_relax    = (r_cmd == CMD_RELAX);

endmodule
`default_nettype wire

// ===== tb/sv/tb_hopfield_network_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hopfield_network_engine_core
// Self-checking bench for the Hopfield coupling engine.
// ----------------------------------------------------------------------------
// Commands stream in through a queue-fed driver and results are checked
// against an in-bench coupling matrix that learns, unlearns and relaxes in
// step with the block. Register settings change between phases only while
// the block is idle. Both stream sides idle at random, and one phase holds
// off the result side long enough to stall the command side.
// ----------------------------------------------------------------------------
module tb_hopfield_network_engine_core;
    import hne_pkg::*;

    localparam int  NN         = 64;
    localparam int  LAT        = 4200;
    localparam int  MAX_CYCLES = 40000000;
    localparam longint W_HI    = 64'sd2147483647;
    localparam longint W_LO    = -64'sd2147483648;

    typedef struct {
        t_cmd        cmd;
        logic [63:0] spins;
    } t_item;

    typedef struct {
        logic [63:0]      final_state;
        logic [CNT_W-1:0] sweeps;
        logic             hit;
        logic             sat;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [63:0] in_data = '0;
    logic [1:0] in_user = '0;
    logic out_ready = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    wire s_ready;
    wire m_valid;
    wire [87:0] m_data;
    wire cfg_ready;

    hopfield_network_engine_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (in_data),   // [63:0] spin_vector
        .i_s_axis_tuser  (in_user),   // [1:0] cmd
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (m_data),    // [63:0] state, [83:64] sweeps, [84] hit, [85] sat
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Bench copy of the coupling matrix and registers
    longint coupling [NN][NN];
    logic [STRENGTH_W-1:0] strength_q = STRENGTH_RESET;
    logic [EQ_W-1:0]       eq_q       = EQ_RESET;
    logic [CNT_W-1:0]      limit_q    = LIMIT_RESET;

    t_item   cmd_queue[$];
    t_result expected_results[$];

    bit in_took = 0, out_took = 0, cfg_took = 0;
    bit no_idle = 0, hold_start = 0, failed = 0;
    int in_gap = 0, out_stall = 0, hold_left = 0;
    int mismatches = 0, results_checked = 0, cycles = 0;
    int cmd_seen [4];

    function automatic bit hebb_add(logic [63:0] v, longint delta);
        bit sat;
        longint w;
        sat = 0;
        for (int i = 0; i < NN; i++) begin
            for (int j = i + 1; j < NN; j++) begin
                w = coupling[i][j] + ((v[i] == v[j]) ? delta : -delta);
                if (w > W_HI) begin
                    w = W_HI;
                    sat = 1;
                end
                if (w < W_LO) begin
                    w = W_LO;
                    sat = 1;
                end
                coupling[i][j] = w;
                coupling[j][i] = w;
            end
        end
        return sat;
    endfunction

    function automatic logic [63:0] sweep_once(logic [63:0] s);
        logic [63:0] r;
        longint field;
        r = '0;
        for (int i = 0; i < NN; i++) begin
            field = 0;
            for (int j = 0; j < NN; j++)
                field += s[j] ? coupling[i][j] : -coupling[i][j];
            r[i] = (field > 0);
        end
        return r;
    endfunction

    function automatic t_result run_command(t_cmd cmd, logic [63:0] v);
        t_result res;
        logic [63:0] cur, prev, nxt;
        bit have_prev;
        int count, conv, rest;
        res = '{default: '0};
        case (cmd)
            CMD_CLEAR: begin
                foreach (coupling[i, j]) coupling[i][j] = 0;
            end
            CMD_LEARN: res.sat = hebb_add(v, 64'sd65536);
            CMD_UNLEARN: res.sat = hebb_add(v, -longint'(strength_q));
            default: begin
                cur = v;
                prev = v;
                have_prev = 0;
                count = 0;
                conv = 0;
                while (conv < int'(eq_q) && count < int'(limit_q)) begin
                    nxt = sweep_once(cur);
                    count++;
                    if (nxt == cur) begin
                        conv++;
                    end else if (have_prev && nxt == prev) begin
                        // oscillation between two states: jump straight to the limit, keep parity
                        rest = int'(limit_q) - count;
                        cur = rest[0] ? cur : nxt;
                        count = int'(limit_q);
                        break;
                    end
                    prev = cur;
                    have_prev = 1;
                    cur = nxt;
                end
                res.final_state = cur;
                res.sweeps = count[CNT_W-1:0];
                res.hit = (conv < int'(eq_q));
            end
        endcase
        return res;
    endfunction

    // Command driver
    always @(negedge i_clk) begin
        t_item it;
        logic nv;
        if (i_rst_n) begin
            nv = in_valid;
            if (in_valid && in_took) begin
                nv = 1'b0;
                in_took = 0;
                in_gap = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (!nv) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (cmd_queue.size() > 0) begin
                    it = cmd_queue.pop_front();
                    in_data <= it.spins;
                    in_user <= it.cmd;
                    nv = 1'b1;
                end
            end
            in_valid <= nv;
        end
    end

    // Result side backpressure
    always @(negedge i_clk) begin
        if (out_took) begin
            out_took = 0;
            out_stall = no_idle ? 0 : $urandom_range(0, 6);
        end
        if (out_stall > 0) begin
            out_stall--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= i_rst_n && (hold_left == 0);
        end
    end

    // Long hold-off of the result side
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_start = 0;
            hold_left <= 3 * LAT;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: predict on command transfer, check on result transfer
    always @(posedge i_clk) begin
        t_result exp_r;
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cfg_took = 1;
                case (t_cfg_idx'(cfg_index))
                    CFG_STRENGTH: strength_q = cfg_data;
                    CFG_EQ:       eq_q = cfg_data[EQ_W-1:0];
                    CFG_LIMIT:    limit_q = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && s_ready) begin
                in_took = 1;
                cmd_seen[in_user]++;
                expected_results.push_back(run_command(t_cmd'(in_user), in_data));
            end
            if (m_valid && out_ready) begin
                out_took = 1;
                results_checked++;
                if (expected_results.size() == 0) begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", m_data);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_data[63:0] !== exp_r.final_state || m_data[83:64] !== exp_r.sweeps
                            || m_data[84] !== exp_r.hit || m_data[85] !== exp_r.sat
                            || m_data[87:86] !== 2'b00) begin
                        failed = 1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: exp state %h sweeps %0d hit %b sat %b, got state %h sweeps %0d hit %b sat %b pad %b",
                                results_checked, exp_r.final_state, exp_r.sweeps,
                                exp_r.hit, exp_r.sat, m_data[63:0], m_data[83:64],
                                m_data[84], m_data[85], m_data[87:86]);
                    end
                end
            end
        end
    end

    task automatic push_cmd(t_cmd c, logic [63:0] v);
        t_item it;
        it.cmd = c;
        it.spins = v;
        cmd_queue.push_back(it);
    endtask

    task automatic wait_idle();
        while (cmd_queue.size() > 0 || in_valid || expected_results.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(negedge i_clk); while (!cfg_took);
        cfg_took = 0;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand_spins();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] flip_some(logic [63:0] v, int n);
        repeat (n) v[$urandom_range(0, 63)] ^= 1'b1;
        return v;
    endfunction

    initial begin
        logic [63:0] pats [3];
        logic [63:0] alt;
        int r;
        foreach (coupling[i, j]) coupling[i][j] = 0;
        alt = 64'hAAAA_AAAA_AAAA_AAAA;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Defaults: empty matrix relaxes to all -1 and settles
        push_cmd(CMD_RELAX, '1);
        wait_idle();

        write_reg(CFG_EQ, 20'd2);
        write_reg(CFG_LIMIT, 20'd6);
        push_cmd(CMD_LEARN, alt);
        push_cmd(CMD_LEARN, '1);
        push_cmd(CMD_LEARN, '0);
        push_cmd(CMD_RELAX, alt);
        push_cmd(CMD_RELAX, flip_some(alt, 5));
        push_cmd(CMD_UNLEARN, alt);
        push_cmd(CMD_UNLEARN, '1);
        push_cmd(CMD_RELAX, '1);
        push_cmd(CMD_RELAX, '0);
        push_cmd(CMD_CLEAR, rand_spins());
        push_cmd(CMD_RELAX, ~alt);
        wait_idle();

        // Strongest unlearning of one pattern makes it oscillate with its inverse
        write_reg(CFG_STRENGTH, 20'd0);
        push_cmd(CMD_UNLEARN, rand_spins());
        wait_idle();
        write_reg(CFG_STRENGTH, 20'hFFFFF);
        write_reg(CFG_EQ, 20'd3);
        write_reg(CFG_LIMIT, 20'd1000000);
        push_cmd(CMD_CLEAR, '0);
        push_cmd(CMD_UNLEARN, alt);
        push_cmd(CMD_RELAX, alt);
        push_cmd(CMD_RELAX, ~alt);
        wait_idle();
        write_reg(CFG_LIMIT, 20'd7);
        push_cmd(CMD_RELAX, alt);
        wait_idle();

        // Zero equilibrium count, zero limit, widest count with one sweep
        write_reg(CFG_EQ, 20'd0);
        push_cmd(CMD_RELAX, alt);
        wait_idle();
        write_reg(CFG_EQ, 20'd1);
        write_reg(CFG_LIMIT, 20'd0);
        push_cmd(CMD_RELAX, alt);
        wait_idle();
        write_reg(CFG_EQ, 20'd255);
        write_reg(CFG_LIMIT, 20'd1);
        push_cmd(CMD_RELAX, alt);
        wait_idle();
        write_reg(CFG_EQ, 20'd1);
        write_reg(CFG_LIMIT, 20'd1000000);
        push_cmd(CMD_CLEAR, '1);
        push_cmd(CMD_RELAX, rand_spins());
        wait_idle();

        // Random phases: learn and unlearn three patterns and recall noisy copies, in random order with clears
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_STRENGTH, CFG_DATA_W'($urandom_range(0, 20'hFFFFF)));
            write_reg(CFG_EQ, CFG_DATA_W'($urandom_range(1, 3)));
            write_reg(CFG_LIMIT, CFG_DATA_W'($urandom_range(1, 8)));
            no_idle = (ph == 2);
            foreach (pats[k]) pats[k] = rand_spins();
            for (int n = 0; n < 24; n++) begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    push_cmd(CMD_CLEAR, rand_spins());
                else if (r < 40)
                    push_cmd(CMD_LEARN, pats[$urandom_range(0, 2)]);
                else if (r < 58)
                    push_cmd(CMD_UNLEARN, r[0] ? rand_spins() : pats[$urandom_range(0, 2)]);
                else if (r < 90)
                    push_cmd(CMD_RELAX, flip_some(pats[$urandom_range(0, 2)],
                                                 $urandom_range(0, 10)));
                else
                    push_cmd(CMD_RELAX, rand_spins());
            end
            if (ph == 3) begin
                @(negedge i_clk);
                hold_start = 1;
            end
            wait_idle();
        end
        no_idle = 0;

        repeat (LAT) @(negedge i_clk);
        if (expected_results.size() != 0)
            failed = 1;
        $display("covered %0d clear, %0d learn, %0d unlearn, %0d relax commands",
            cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
        $display("%0d results checked, %0d mismatches, %0d left unmatched",
            results_checked, mismatches, expected_results.size());
        if (!failed)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
